// ----- src/tcdt_pkg.sv -----
// ============================================================================
// tcdt_pkg: shared types and constants for the tick to civil date/time core
// Reciprocal multipliers for the constant divisions, register indexes and
// the result item layout.
// ============================================================================
`default_nettype none

package tcdt_pkg;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_BASE_SECONDS = 1'b0,
    CFG_BASE_TICK_MS = 1'b1
  } cfg_idx_t;

  // time constants
  localparam logic [31:0] SecPerDay  = 32'd86400;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [11:0] SecPerMin  = 12'd60;

  // calendar constants, day 0 is 0000-03-01
  localparam logic [19:0] DaysTo0300 = 20'd719468;
  localparam logic [19:0] EraStart4  = 20'd584388;   // 4 * 146097
  localparam logic [19:0] EraStart5  = 20'd730485;   // 5 * 146097
  localparam logic [11:0] EraYear4   = 12'd1600;
  localparam logic [11:0] EraYear5   = 12'd2000;

  // round-up reciprocals, exact over the operand range in use
  localparam logic [28:0] DivMsMul   = 29'd274877907;   // /1000, shift 38
  localparam logic [31:0] DivDayMul  = 32'd3257812231;  // /86400, shift 48
  localparam logic [17:0] DivHourMul = 18'd149131;      // /3600, shift 29
  localparam logic [12:0] DivMinMul  = 13'd4370;        // /60, shift 18
  localparam logic [18:0] Div1460Mul = 19'd367720;      // /1460, shift 29
  localparam logic [18:0] Div365Mul  = 19'd367720;      // /365, shift 27
  localparam logic [11:0] Div153Mul  = 12'd3427;        // /153, shift 19

  // one result item, year in the low bits
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } result_t;

  // days before the start of shifted month mp (march based): (153*mp+2)/5
  function automatic logic [8:0] mp_day_offset(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/tick_to_civil_date_time_core.sv -----
// ============================================================================
// tick_to_civil_date_time_core: millisecond tick to UTC calendar date and time
// Thirteen-stage pipeline from a 32-bit tick sample to year/month/day and
// hour/minute/second, followed by a two-entry output buffer.
// ============================================================================
// Each accepted tick sample yields exactly one result transaction. The core
// takes one sample per clock while the skid entry of the output buffer is
// free; a result is offered once its sample has passed the 13 pipeline
// stages and the output register. The clock rate is
// set by the widest stage, the 32x32 reciprocal multiply that splits seconds
// into days. Elapsed time is (now_ms - base_tick_ms) mod 2^32 divided by 1000,
// added to base_seconds mod 2^32, so every input maps to a date between 1970
// and 2106. When the output is stalled the pipeline freezes as a whole once
// the skid entry is occupied; no transaction is dropped or duplicated.
// Configuration writes are meant to happen while no transaction is in flight.
// ============================================================================
`default_nettype none

module tick_to_civil_date_time_core (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  tcdt_pkg::cfg_idx_t   cfg_index,
  input  logic [31:0]          cfg_data,
  // tick samples in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [31:0] now_ms
  // date/time results out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata    // [11:0] year, [15:12] month,
                                               // [20:16] day, [25:21] hour,
                                               // [31:26] minute, [37:32] second,
                                               // [39:38] zero
);
  import tcdt_pkg::*;

  localparam int unsigned NumStages = 13;

  typedef struct packed {
    logic [4:0] hh;
    logic [5:0] mi;
    logic [5:0] ss;
  } tod_t;

  // configuration registers
  logic [31:0] base_seconds;
  logic [31:0] base_tick_ms;

  // pipeline control: one valid bit per stage, whole pipe advances on ce
  logic                 ce;
  logic [NumStages-1:0] vld;

  // stage registers
  logic [31:0] s1_elap;
  logic [60:0] s2_prod;
  logic [31:0] s3_secs;
  logic [63:0] s4_prod;
  logic [31:0] s4_secs;
  logic [15:0] s5_days;
  logic [16:0] s5_rem;
  logic [17:0] s6_doe;
  logic        s6_era_hi;
  logic [34:0] s6_ph;
  logic [16:0] s6_rem;
  logic [36:0] s7_aprod;
  logic [2:0]  s7_b;
  logic        s7_c;
  logic [17:0] s7_doe;
  logic        s7_era_hi;
  logic [4:0]  s7_hh;
  logic [11:0] s7_rh;
  logic [17:0] s8_t;
  logic [17:0] s8_doe;
  logic        s8_era_hi;
  logic [4:0]  s8_hh;
  logic [11:0] s8_rh;
  logic [24:0] s8_pm;
  logic [36:0] s9_py;
  logic [17:0] s9_doe;
  logic        s9_era_hi;
  tod_t        s9_tod;
  logic [8:0]  s10_yoe;
  logic [11:0] s10_y;
  logic [17:0] s10_doe;
  tod_t        s10_tod;
  logic [8:0]  s11_doy;
  logic [11:0] s11_y;
  tod_t        s11_tod;
  logic [22:0] s12_pm;
  logic [8:0]  s12_doy;
  logic [11:0] s12_y;
  tod_t        s12_tod;
  result_t     s13_res;

  // stage logic
  logic [31:0] elap_c;
  logic [60:0] prod1_c;
  logic [31:0] secs_c;
  logic [63:0] prod2_c;
  logic [15:0] days_c;
  logic [31:0] dsec_c;
  logic [16:0] rem_c;
  logic [19:0] z_c;
  logic        era_hi_c;
  logic [17:0] doe_c;
  logic [34:0] ph_c;
  logic [36:0] aprod_c;
  logic [2:0]  b_c;
  logic        c_c;
  logic [4:0]  hh_c;
  logic [11:0] rh_c;
  logic [6:0]  a_c;
  logic [17:0] t_c;
  logic [24:0] pmin_c;
  logic [36:0] py_c;
  logic [5:0]  mi_c;
  logic [5:0]  ss_c;
  logic [8:0]  yoe_c;
  logic [11:0] y_c;
  logic [1:0]  c100_c;
  logic [17:0] yday_c;
  logic [8:0]  doy_c;
  logic [10:0] mpp_c;
  logic [22:0] pm_c;
  logic [3:0]  mp_c;
  logic [3:0]  m_c;
  result_t     res_c;

  result_t     out_res;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seconds <= 32'd0;
      base_tick_ms <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_SECONDS: base_seconds <= cfg_data;
        CFG_BASE_TICK_MS: base_tick_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath, one register stage per step below
  // --------------------------------------------------------------------------
  always_comb begin
    // s1: elapsed ms, wraps at 2^32
    elap_c   = s_axis_tdata - base_tick_ms;
    // s2: ms to seconds, reciprocal product
    prod1_c  = 61'(s1_elap) * 61'(DivMsMul);
    // s3: add base seconds, wraps at 2^32
    secs_c   = base_seconds + {9'd0, s2_prod[60:38]};
    // s4: seconds to days, reciprocal product
    prod2_c  = 64'(s3_secs) * 64'(DivDayMul);
    // s5: day count and second of day
    days_c   = s4_prod[63:48];
    dsec_c   = {16'd0, days_c} * SecPerDay;
    rem_c    = 17'(s4_secs - dsec_c);
    // s6: day of 400-year era; only eras 4 and 5 are reachable
    z_c      = 20'(s5_days) + DaysTo0300;
    era_hi_c = (z_c >= EraStart5);
    doe_c    = 18'(z_c - (era_hi_c ? EraStart5 : EraStart4));
    ph_c     = 35'(s5_rem) * 35'(DivHourMul);
    // s7: doe/1460 product, century corrections, hour split
    aprod_c  = 37'(s6_doe) * 37'(Div1460Mul);
    b_c      = 3'(s6_doe >= 18'd36524) + 3'(s6_doe >= 18'd73048)
             + 3'(s6_doe >= 18'd109572) + 3'(s6_doe >= 18'd146096);
    c_c      = (s6_doe >= 18'd146096);
    hh_c     = s6_ph[33:29];
    rh_c     = 12'(s6_rem - 17'(hh_c) * SecPerHour);
    // s8: leap-adjusted day of era, minute product
    a_c      = s7_aprod[35:29];
    t_c      = s7_doe - 18'(a_c) + 18'(s7_b) - 18'(s7_c);
    pmin_c   = 25'(s7_rh) * 25'(DivMinMul);
    // s9: year of era product, minute and second
    py_c     = 37'(s8_t) * 37'(Div365Mul);
    mi_c     = s8_pm[23:18];
    ss_c     = 6'(s8_rh - 12'(mi_c) * SecPerMin);
    // s10: year of era and march-based year
    yoe_c    = s9_py[35:27];
    y_c      = 12'(yoe_c) + (s9_era_hi ? EraYear5 : EraYear4);
    // s11: day of year from march 1
    c100_c   = 2'(s10_yoe >= 9'd100) + 2'(s10_yoe >= 9'd200) + 2'(s10_yoe >= 9'd300);
    yday_c   = 18'(s10_yoe) * 18'd365 + 18'(s10_yoe[8:2]) - 18'(c100_c);
    doy_c    = 9'(s10_doe - yday_c);
    // s12: shifted month product
    mpp_c    = 11'(s11_doy) * 11'd5 + 11'd2;
    pm_c     = 23'(mpp_c) * 23'(Div153Mul);
    // s13: month, day, january/february roll into next year
    mp_c     = s12_pm[22:19];
    m_c      = (mp_c < 4'd10) ? 4'(mp_c + 4'd3) : 4'(mp_c - 4'd9);
    res_c.year   = s12_y + 12'(m_c <= 4'd2);
    res_c.month  = m_c;
    res_c.day    = 5'(s12_doy - mp_day_offset(mp_c) + 9'd1);
    res_c.hour   = s12_tod.hh;
    res_c.minute = s12_tod.mi;
    res_c.second = s12_tod.ss;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NumStages-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_elap   <= elap_c;
      s2_prod   <= prod1_c;
      s3_secs   <= secs_c;
      s4_prod   <= prod2_c;
      s4_secs   <= s3_secs;
      s5_days   <= days_c;
      s5_rem    <= rem_c;
      s6_doe    <= doe_c;
      s6_era_hi <= era_hi_c;
      s6_ph     <= ph_c;
      s6_rem    <= s5_rem;
      s7_aprod  <= aprod_c;
      s7_b      <= b_c;
      s7_c      <= c_c;
      s7_doe    <= s6_doe;
      s7_era_hi <= s6_era_hi;
      s7_hh     <= hh_c;
      s7_rh     <= rh_c;
      s8_t      <= t_c;
      s8_doe    <= s7_doe;
      s8_era_hi <= s7_era_hi;
      s8_hh     <= s7_hh;
      s8_rh     <= s7_rh;
      s8_pm     <= pmin_c;
      s9_py     <= py_c;
      s9_doe    <= s8_doe;
      s9_era_hi <= s8_era_hi;
      s9_tod    <= '{hh: s8_hh, mi: mi_c, ss: ss_c};
      s10_yoe   <= yoe_c;
      s10_y     <= y_c;
      s10_doe   <= s9_doe;
      s10_tod   <= s9_tod;
      s11_doy   <= doy_c;
      s11_y     <= s10_y;
      s11_tod   <= s10_tod;
      s12_pm    <= pm_c;
      s12_doy   <= s11_doy;
      s12_y     <= s11_y;
      s12_tod   <= s11_tod;
      s13_res   <= res_c;
    end
  end

  // --------------------------------------------------------------------------
  // output buffer; its free skid entry gates the whole pipeline
  // --------------------------------------------------------------------------
  tcdt_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[NumStages-1] && ce),
    .in_data   (s13_res),
    .in_ready  (ce),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign s_axis_tready = ce;
  assign m_axis_tdata  = {2'b00, out_res};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // every delivered result has month 1 to 12, day at least 1, a legal time of day and year 1970 to 2106
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_res.month >= 4'd1 && out_res.month <= 4'd12 &&
                       out_res.day >= 5'd1 && out_res.hour <= 5'd23 &&
                       out_res.minute <= 6'd59 && out_res.second <= 6'd59 &&
                       out_res.year >= 12'd1970 && out_res.year <= 12'd2106))
    else $error("result field out of range");

  // pipeline only stalls when the output register holds a result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !ce |-> m_axis_tvalid)
    else $error("pipeline stalled with empty output");

  // a taken result with a parked one behind it keeps the output valid
  a_skid_refill: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !ce) |=> m_axis_tvalid)
    else $error("parked result lost");

  // an accepted sample enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted sample not in pipeline");

endmodule

`default_nettype wire

// ----- src/tcdt_out_buf.sv -----
// ============================================================================
// tcdt_out_buf: two-entry output buffer
// Output register plus skid entry; upstream ready comes from a register only.
// ============================================================================
`default_nettype none

module tcdt_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tcdt_pkg::result_t in_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tcdt_pkg::result_t out_data
);
  import tcdt_pkg::*;

  logic    hold_valid;
  result_t hold_data;
  logic    skid_valid;
  result_t skid_data;
  logic    push;
  logic    pop;

  assign in_ready  = !skid_valid;
  assign push      = in_valid && !skid_valid;
  assign pop       = hold_valid && out_ready;
  assign out_valid = hold_valid;
  assign out_data  = hold_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !hold_valid) begin
      if (skid_valid) begin
        hold_data  <= skid_data;
        hold_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        hold_valid <= push;
        if (push) begin
          hold_data <= in_data;
        end
      end
    end else if (push) begin
      // output still waiting, park the new result
      skid_valid <= 1'b1;
      skid_data  <= in_data;
    end
  end

endmodule

`default_nettype wire
